/* rtl/bitmap_frame_allocator_unit_macros.svh */
// assertion macros for the bitmap frame allocator
// no dependencies
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BFA_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error("lbl failed");
`define BFA_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error("lbl failed");
`else
`define BFA_ASSERT(lbl, clk_s, rst_s, prop)
`define BFA_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

/* rtl/bfa_pkg.sv */
// shared types and constants for the bitmap frame allocator
// no dependencies
`default_nettype none
package bfa_pkg;
  localparam int unsigned MAX_FRAMES_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF  = 32;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned FRAME_W  = 12;

  typedef enum logic [1:0] {
    CMD_RELEASE = 2'd0,
    CMD_RESERVE = 2'd1,
    CMD_ALLOC   = 2'd2,
    CMD_FREE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_RANGE   = 2'd2,
    ST_ZERO    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN,
    S_MOD_RD,
    S_MOD_WAIT,
    S_MOD_WR,
    S_ZERO_RD,
    S_ZERO_WAIT,
    S_ZERO_WR,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

/* rtl/bitmap_frame_allocator_unit.sv */
// bitmap frame allocator top level: command sequencer over the frame map
// depends on bfa_pkg, bfa_map_ram and the assertion macro header
//
// One command is taken at a time and answered with one result transfer.
// The used map lives in a synchronous ram of MAX_FRAMES/WORD_BITS words,
// rounded up, and every pass over it reads through the registered port.
// After reset, or after a write of total_frames, an init sweep over all
// MAP_WORDS words sets every word to all ones; commands wait meanwhile.
// Zero-count and range errors go from the check state straight to the
// result. Region and free commands read, wait and write back each word
// that the region touches. Region commands then read and force frame 0
// used. Allocate first scans words 0 up to the last managed word, one
// word a cycle, and stops early when the run is found. It then writes
// the run back. The result sits in an output register until it is taken;
// stall on the result side holds the block.
`default_nettype none
`include "bitmap_frame_allocator_unit_macros.svh"
module bitmap_frame_allocator_unit #(
  parameter int unsigned MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF,
  parameter int unsigned WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [bfa_pkg::CNT_W-1:0]   cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  cmd,
  input  wire logic [bfa_pkg::FRAME_W-1:0] first_frame,
  input  wire logic [bfa_pkg::CNT_W-1:0]   frame_count,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       status,
  output logic [bfa_pkg::FRAME_W-1:0]      start_frame,
  output logic [bfa_pkg::CNT_W-1:0]        free_count,
  output logic [bfa_pkg::CNT_W-1:0]        used_count
);
  import bfa_pkg::*;

  localparam int unsigned MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BW  = $clog2(WORD_BITS);
  // frame indices and counts held wide enough for the range check
  localparam int unsigned FW  = CNT_W + 1;
  localparam logic [CNT_W-1:0] MAX_TOT =
    (MAX_FRAMES > 4096) ? CNT_W'(4096) : CNT_W'(MAX_FRAMES);

  state_t state, state_next;

  // configuration and counters
  logic [CNT_W-1:0] total_frames;
  logic [CNT_W-1:0] free_frames;

  // latched command
  cmd_t             c_cmd;
  logic [CNT_W-1:0] c_count;

  // working registers
  logic [AW-1:0]    waddr_cur;   // word under read / modify
  logic [AW-1:0]    w_last;      // last word of the region
  logic [FW-1:0]    run;         // free run length during scan
  logic [FW-1:0]    reg_lo;      // region first frame
  logic [FW-1:0]    reg_hi;      // region last frame (inclusive)
  logic [1:0]       r_status;
  logic [FRAME_W-1:0] r_start;
  logic             found;

  // ram ports
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  bfa_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // last managed word
  logic [FW-1:0] tot_m1;
  logic [AW-1:0] tot_last_w;
  assign tot_m1     = FW'(total_frames) - FW'(1);
  assign tot_last_w = AW'(tot_m1 >> BW);

  // scan of one word: the run at each bit follows from the last used bit at
  // or below it, so every bit is checked on its own; lowest hit wins
  logic [FW-1:0] scan_run;
  logic          scan_hit;
  logic [FW-1:0] scan_end;
  logic [FW-1:0] scan_start;
  always_comb begin
    logic [FW-1:0] r;
    logic [FW-1:0] f;
    logic [BW-1:0] last_used;
    logic          any_used;
    any_used  = 1'b0;
    last_used = '0;
    r         = run;
    scan_hit  = 1'b0;
    scan_end  = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      f = FW'({waddr_cur, BW'(b)});
      // frames past the managed range break a run
      if (ram_rdata[b] || f >= FW'(total_frames)) begin
        any_used  = 1'b1;
        last_used = BW'(b);
      end
      r = any_used ? FW'(b) - FW'(last_used) : run + FW'(b) + FW'(1);
      if (!scan_hit && r == FW'(c_count)) begin
        scan_hit = 1'b1;
        scan_end = f;
      end
    end
    scan_run = r;
  end
  assign scan_start = scan_end + FW'(1) - FW'(c_count);

  // modify of one word: bits inside [reg_lo, reg_hi]
  logic [WORD_BITS-1:0] reg_mask;
  always_comb begin
    logic [FW-1:0] f;
    for (int b = 0; b < WORD_BITS; b++) begin
      f = FW'({waddr_cur, BW'(b)});
      reg_mask[b] = (f >= reg_lo) && (f <= reg_hi);
    end
  end

  logic                 set_used;
  logic [WORD_BITS-1:0] mod_word;
  logic [WORD_BITS-1:0] flip_bits;
  logic [BW:0]          flip_n;
  assign set_used  = (c_cmd == CMD_ALLOC) || (c_cmd == CMD_RESERVE);
  assign mod_word  = set_used ? (ram_rdata | reg_mask) : (ram_rdata & ~reg_mask);
  assign flip_bits = ram_rdata ^ mod_word;
  always_comb begin
    flip_n = '0;
    for (int b = 0; b < WORD_BITS; b++) flip_n = flip_n + (BW+1)'(flip_bits[b]);
  end

  logic [FW-1:0] in_end;
  assign in_end = FW'(first_frame) + FW'(frame_count);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:      if (waddr_cur == AW'(MAP_WORDS - 1)) state_next = S_IDLE;
      S_IDLE:      if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (r_status != ST_OK)        state_next = S_DONE;
        else if (c_cmd == CMD_ALLOC)  state_next = S_SCAN_RD;
        else                          state_next = S_MOD_RD;
      end
      S_SCAN_RD:   state_next = S_SCAN;
      S_SCAN: begin
        if (scan_hit)                       state_next = S_MOD_RD;
        else if (waddr_cur == tot_last_w)   state_next = S_DONE;
        else                                state_next = S_SCAN;
      end
      S_MOD_RD:    state_next = S_MOD_WAIT;
      S_MOD_WAIT:  state_next = S_MOD_WR;
      S_MOD_WR: begin
        if (waddr_cur != w_last)            state_next = S_MOD_RD;
        else if (c_cmd == CMD_RELEASE || c_cmd == CMD_RESERVE) state_next = S_ZERO_RD;
        else                                state_next = S_DONE;
      end
      S_ZERO_RD:   state_next = S_ZERO_WAIT;
      S_ZERO_WAIT: state_next = S_ZERO_WR;
      S_ZERO_WR:   state_next = S_DONE;
      S_DONE:      if (!out_stall) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
    if (cfg_we) state_next = S_INIT;
  end

  // ram access by state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = waddr_cur;
    ram_wdata = mod_word;
    ram_raddr = waddr_cur;
    unique case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '1;
      end
      S_SCAN_RD, S_SCAN: ram_raddr = (state == S_SCAN) ? waddr_cur + AW'(1) : waddr_cur;
      S_MOD_WR:  ram_we = 1'b1;
      S_ZERO_RD, S_ZERO_WAIT: ram_raddr = '0;
      S_ZERO_WR: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = ram_rdata | WORD_BITS'(1);
      end
      default: ;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);
  assign status      = r_status;
  assign start_frame = r_start;
  assign free_count  = free_frames;
  assign used_count  = total_frames - free_frames;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      total_frames <= MAX_TOT;
      free_frames  <= '0;
      waddr_cur    <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        // zero taken as one, capped at the map size
        if (cfg_wdata == '0)          total_frames <= CNT_W'(1);
        else if (cfg_wdata > MAX_TOT) total_frames <= MAX_TOT;
        else                          total_frames <= cfg_wdata;
        free_frames <= '0;
        waddr_cur   <= '0;
      end else begin
        case (state)
          S_INIT:   waddr_cur <= waddr_cur + AW'(1);
          S_CHECK: begin
            waddr_cur <= (c_cmd == CMD_ALLOC) ? '0 : AW'(reg_lo >> BW);
          end
          S_SCAN: begin
            // modify pass starts at the run's first word after a hit
            if (scan_hit) waddr_cur <= AW'(scan_start >> BW);
            else          waddr_cur <= waddr_cur + AW'(1);
          end
          S_MOD_WR: begin
            if (set_used) free_frames <= free_frames - CNT_W'(flip_n);
            else          free_frames <= free_frames + CNT_W'(flip_n);
            waddr_cur <= waddr_cur + AW'(1);
          end
          S_ZERO_WR: begin
            if (!ram_rdata[0]) free_frames <= free_frames - CNT_W'(1);
          end
          default: ;
        endcase
      end
    end
  end

  // command registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        c_cmd   <= cmd_t'(cmd);
        c_count <= frame_count;
        reg_lo  <= FW'(first_frame);
        reg_hi  <= in_end - FW'(1);
        w_last  <= AW'((in_end - FW'(1)) >> BW);
        run     <= '0;
        found   <= 1'b0;
        r_start <= '0;
        if (frame_count == '0)
          r_status <= ST_ZERO;
        else if (cmd_t'(cmd) == CMD_ALLOC)
          r_status <= (frame_count > total_frames) ? ST_RANGE :
                      (free_frames < frame_count) ? ST_NO_FIT : ST_OK;
        else
          r_status <= (in_end > FW'(total_frames)) ? ST_RANGE : ST_OK;
      end
      S_SCAN: begin
        run <= scan_run;
        if (scan_hit) begin
          found     <= 1'b1;
          reg_lo    <= scan_start;
          reg_hi    <= scan_end;
          w_last    <= AW'(scan_end >> BW);
          r_start   <= FRAME_W'(scan_start);
        end else if (waddr_cur == tot_last_w) begin
          r_status  <= ST_NO_FIT;
        end
      end
      default: ;
    endcase
  end

  `BFA_ASSERT(a_out_only_done, clk, rst, out_valid |-> (state == S_DONE))
  `BFA_ASSERT(a_free_le_total, clk, rst, free_frames <= total_frames)
  `BFA_ASSERT(a_start_zero_fail, clk, rst, (out_valid && status != ST_OK) |-> (start_frame == '0))
  `BFA_ASSERT(a_found_ok, clk, rst, (out_valid && c_cmd == CMD_ALLOC && status == ST_OK) |-> found)
endmodule
`default_nettype wire

/* rtl/bfa_map_ram.sv */
// frame map storage: one write port, one registered read port
// depends on nothing but its parameters
`default_nettype none
module bfa_map_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
